// File: rtl/krt_pkg.sv
package krt_pkg;

	// table geometry
	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int KEY_W       = 32;
	localparam int MARK_W      = 10;
	localparam int ACT_W       = 2;
	localparam int STAT_W      = 2;

	localparam logic [MARK_W-1:0] MARK_LIMIT = MARK_W'(1000);
	localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_ENTRIES);

	// action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUP     = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

	// write port of the entry store
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [KEY_W-1:0]  key;
		logic [MARK_W-1:0] mark;
	} store_wr_t;

endpackage

// File: rtl/krt_req_if.sv
interface krt_req_if;
	logic                             valid;
	logic                             ready;
	logic [krt_pkg::ACT_W-1:0]        action;
	logic signed [krt_pkg::KEY_W-1:0] key;
	logic [krt_pkg::MARK_W-1:0]       mark_value;

	modport source (output valid, action, key, mark_value, input ready);
	modport sink   (input valid, action, key, mark_value, output ready);
endinterface

// File: rtl/krt_rsp_if.sv
interface krt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [krt_pkg::STAT_W-1:0]  status;
	logic [krt_pkg::IDX_W-1:0]   entry_index;
	logic [krt_pkg::MARK_W-1:0]  mark_out;
	logic [krt_pkg::CNT_W-1:0]   occupancy;

	modport source (output valid, status, entry_index, mark_out, occupancy, input ready);
	modport sink   (input valid, status, entry_index, mark_out, occupancy, output ready);
endinterface

// File: rtl/krt_store.sv
module krt_store (
	input  logic                        clk,
	input  krt_pkg::store_wr_t          wr,
	input  logic [krt_pkg::IDX_W-1:0]   raddr,
	output logic [krt_pkg::KEY_W-1:0]   rkey,
	output logic [krt_pkg::MARK_W-1:0]  rmark
);

	logic [krt_pkg::KEY_W-1:0]  key_mem  [krt_pkg::MAX_ENTRIES];
	logic [krt_pkg::MARK_W-1:0] mark_mem [krt_pkg::MAX_ENTRIES];

	// single write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			key_mem[wr.addr]  <= wr.key;
			mark_mem[wr.addr] <= wr.mark;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rkey  <= key_mem[raddr];
		rmark <= mark_mem[raddr];
	end

endmodule

// File: rtl/keyed_record_table.sv
// keyed_record_table: unsorted table of up to 64 entries (signed key, mark in tenths)
// with a linear key search over an entry memory with one write and one read port.
// req channel carries action, key and mark_value; rsp channel returns status,
// entry_index, mark_out and occupancy. Each request gives exactly one response.
// req.ready is high only while the sequencer is idle; one request is worked on
// at a time.
// The memory read is registered and one entry is compared per cycle during a
// search. A delete then moves the entries behind the match down one place.
// The response register is loaded from S_RESP once the register is free.
// An insert on a full table answers without a search.
// Reset clears the entry count and the sequencer; the memory itself is not cleared,
// only entries below the count are ever used.
// The response sits in an output register until rsp.ready; a new request is
// taken meanwhile, and its result waits in the sequencer until the register frees.
module keyed_record_table (
	input  logic clk,
	input  logic arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	state_t state_q;

	krt_pkg::action_t            act_q;
	logic [krt_pkg::KEY_W-1:0]   key_q;
	logic [krt_pkg::MARK_W-1:0]  mark_q;
	logic [krt_pkg::CNT_W-1:0]   cnt_q;
	logic [krt_pkg::CNT_W-1:0]   iss_q;
	logic [krt_pkg::IDX_W-1:0]   cmp_idx_q;
	logic                        rvalid_q;

	logic [krt_pkg::STAT_W-1:0]  res_status_q;
	logic [krt_pkg::IDX_W-1:0]   res_idx_q;
	logic [krt_pkg::MARK_W-1:0]  res_mark_q;

	logic                        ovalid_q;
	logic [krt_pkg::STAT_W-1:0]  ostatus_q;
	logic [krt_pkg::IDX_W-1:0]   oidx_q;
	logic [krt_pkg::MARK_W-1:0]  omark_q;
	logic [krt_pkg::CNT_W-1:0]   occ_q;

	krt_pkg::store_wr_t          wr;
	logic [krt_pkg::KEY_W-1:0]   rd_key;
	logic [krt_pkg::MARK_W-1:0]  rd_mark;

	logic                        req_xfer;
	logic                        issue;
	logic                        hit;
	logic                        scan_done;
	logic                        out_free;
	logic [krt_pkg::MARK_W-1:0]  mark_sat;

	krt_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (iss_q[krt_pkg::IDX_W-1:0]),
		.rkey  (rd_key),
		.rmark (rd_mark)
	);

	// handshake and shared compare
	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign issue     = (iss_q < cnt_q);
	assign hit       = rvalid_q && (rd_key == key_q);
	assign scan_done = !rvalid_q && !issue;
	assign out_free  = !ovalid_q || rsp.ready;
	assign mark_sat  = (req.mark_value > krt_pkg::MARK_LIMIT) ? krt_pkg::MARK_LIMIT
	                                                          : req.mark_value;

	// memory write requests
	always_comb begin
		wr      = '0;
		wr.key  = key_q;
		wr.mark = mark_q;
		unique case (state_q)
			S_SEARCH: begin
				if (hit && act_q == krt_pkg::ACT_UPDATE) begin
					wr.we   = 1'b1;
					wr.addr = cmp_idx_q;
				end else if (!hit && scan_done && act_q == krt_pkg::ACT_INSERT) begin
					wr.we   = 1'b1;
					wr.addr = cnt_q[krt_pkg::IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				if (rvalid_q) begin
					wr.we   = 1'b1;
					wr.addr = cmp_idx_q - krt_pkg::IDX_W'(1);
					wr.key  = rd_key;
					wr.mark = rd_mark;
				end
			end
			S_IDLE, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			iss_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						iss_q    <= '0;
						rvalid_q <= 1'b0;
						if (krt_pkg::action_t'(req.action) == krt_pkg::ACT_INSERT
						    && cnt_q >= krt_pkg::CNT_FULL) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						if (act_q == krt_pkg::ACT_DELETE) begin
							iss_q    <= {1'b0, cmp_idx_q} + krt_pkg::CNT_W'(1);
							rvalid_q <= 1'b0;
							state_q  <= S_SHIFT;
						end else begin
							state_q <= S_RESP;
						end
					end else if (scan_done) begin
						if (act_q == krt_pkg::ACT_INSERT) begin
							cnt_q <= cnt_q + krt_pkg::CNT_W'(1);
						end
						state_q <= S_RESP;
					end else begin
						iss_q    <= issue ? iss_q + krt_pkg::CNT_W'(1) : iss_q;
						rvalid_q <= issue;
					end
				end
				S_SHIFT: begin
					if (scan_done) begin
						cnt_q   <= cnt_q - krt_pkg::CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						iss_q    <= issue ? iss_q + krt_pkg::CNT_W'(1) : iss_q;
						rvalid_q <= issue;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// compare index follows the issued read address
	always_ff @(posedge clk) begin
		if ((state_q == S_SEARCH || state_q == S_SHIFT) && !hit && !scan_done) begin
			cmp_idx_q <= iss_q[krt_pkg::IDX_W-1:0];
		end
	end

	// request capture and pending result
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			act_q        <= krt_pkg::action_t'(req.action);
			key_q        <= req.key;
			mark_q       <= mark_sat;
			res_status_q <= krt_pkg::ST_FULL;
			res_idx_q    <= '0;
			res_mark_q   <= '0;
		end else if (state_q == S_SEARCH) begin
			if (hit) begin
				unique case (act_q)
					krt_pkg::ACT_INSERT: begin
						res_status_q <= krt_pkg::ST_DUP;
						res_idx_q    <= '0;
						res_mark_q   <= '0;
					end
					krt_pkg::ACT_UPDATE: begin
						res_status_q <= krt_pkg::ST_OK;
						res_idx_q    <= cmp_idx_q;
						res_mark_q   <= mark_q;
					end
					krt_pkg::ACT_LOOKUP, krt_pkg::ACT_DELETE: begin
						res_status_q <= krt_pkg::ST_OK;
						res_idx_q    <= cmp_idx_q;
						res_mark_q   <= rd_mark;
					end
					default: begin
					end
				endcase
			end else if (scan_done) begin
				if (act_q == krt_pkg::ACT_INSERT) begin
					res_status_q <= krt_pkg::ST_OK;
					res_idx_q    <= cnt_q[krt_pkg::IDX_W-1:0];
					res_mark_q   <= mark_q;
				end else begin
					res_status_q <= krt_pkg::ST_MISSING;
					res_idx_q    <= '0;
					res_mark_q   <= '0;
				end
			end
		end
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			ostatus_q <= res_status_q;
			oidx_q    <= res_idx_q;
			omark_q   <= res_mark_q;
			occ_q     <= cnt_q;
		end
	end

	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ostatus_q;
	assign rsp.entry_index = oidx_q;
	assign rsp.mark_out    = omark_q;
	assign rsp.occupancy   = occ_q;

endmodule

// File: rtl/krt_checker.sv
module krt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [krt_pkg::STAT_W-1:0]  status,
	input logic [krt_pkg::IDX_W-1:0]   entry_index,
	input logic [krt_pkg::MARK_W-1:0]  mark_out,
	input logic [krt_pkg::CNT_W-1:0]   occupancy
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
		&& $stable(entry_index) && $stable(mark_out) && $stable(occupancy))
		else $error("response changed while stalled");

	// one request at a time
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// full status only on a full table
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == krt_pkg::ST_FULL |-> occupancy == krt_pkg::CNT_FULL)
		else $error("full status with free entries");

	// failures carry zero index and mark
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != krt_pkg::ST_OK |-> entry_index == '0 && mark_out == '0)
		else $error("failure with nonzero index or mark");

	// occupancy and mark within range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= krt_pkg::CNT_FULL && mark_out <= krt_pkg::MARK_LIMIT)
		else $error("response field out of range");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.entry_index (rsp.entry_index),
	.mark_out    (rsp.mark_out),
	.occupancy   (rsp.occupancy)
);
